// ----- rtl/brb_pkg.sv -----
// Shared types, constants and helpers of the record blocker.
`default_nettype none
package brb_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [23:0] MARKER_HEAD  = 24'h425546;  // "BUF"
    localparam logic [7:0]  MARKER_TAIL  = 8'h52;       // "R"
    localparam logic [31:0] MARKER_WORD  = 32'h52465542; // "BUFR", first byte low
    localparam logic [23:0] HEADER_BYTES = 24'd8;
    localparam logic [7:0]  EDITION_MIN  = 8'd2;

    // One queued command: everything one input byte makes the back end emit.
    typedef struct packed {
        logic        lead_word;   // length word before the body
        logic [63:0] body;        // body bytes, first byte in the low bits
        logic        body_eight;  // body is eight bytes, else one
        logic        err;         // bad header: edition too low or length below the header size
        logic        fin;         // pad bytes and closing length word follow
        logic [3:0]  pad;         // pad count, 1 to 8
        logic [24:0] total;       // record length plus pad
        logic        word_eight;  // length word is eight bytes, else four
    } t_cmd;

    // Record length rounded up to the next multiple of eight above it (a full eight more on a multiple).
    function automatic logic [24:0] f_total(input logic [23:0] len);
        logic [21:0] blocks;
        blocks = {1'b0, len[23:3]} + 22'd1;
        return {blocks, 3'b000};
    endfunction

    function automatic logic [3:0] f_pad(input logic [23:0] len);
        return 4'd8 - {1'b0, len[2:0]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/brb_if.sv -----
// Channel interfaces: input bytes, blocked output bytes, configuration writes.
`default_nettype none
interface brb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface brb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       record_error;
    modport source (output valid, output out_byte, output run_last,
                    output record_error, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input record_error, output ready);
endinterface

interface brb_cfg_if;
    logic valid;
    logic ready;
    logic pad_word_eight;
    modport source (output valid, output pad_word_eight, input ready);
    modport sink   (input valid, input pad_word_eight, output ready);
endinterface
`default_nettype wire

// ----- rtl/brb_front.sv -----
// Front end: marker search, header capture and record copy; issues commands.
`default_nettype none
module brb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    brb_in_if.sink             i_in_ch,
    brb_cfg_if.sink            i_cfg_ch,
    input  wire logic          i_q_full,
    output logic               o_push,
    output brb_pkg::t_cmd      o_cmd
);
    import brb_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HEADER = 2'd1,
        PH_COPY   = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [23:0] r_window, n_window;
    logic [23:0] r_count, n_count;
    logic [23:0] r_len, n_len;
    logic [7:0]  r_hdr [0:2];
    logic        r_word_eight;
    logic        w_accept;
    logic [23:0] w_len_hdr;
    logic [23:0] w_count_inc;
    logic [7:0]  w_d;

    assign i_in_ch.ready  = !i_q_full;
    assign i_cfg_ch.ready = 1'b1;
    assign w_accept       = i_in_ch.valid && !i_q_full;
    assign w_d            = i_in_ch.data_byte;
    assign w_len_hdr      = {r_hdr[0], r_hdr[1], r_hdr[2]};
    assign w_count_inc    = r_count + 24'd1;

    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_count  = r_count;
        n_len    = r_len;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_cmd.word_eight = r_word_eight;
        unique case (r_phase)
            PH_HEADER: begin
                n_count = w_count_inc;
                if (r_count[2:0] == 3'd7) begin
                    n_len  = w_len_hdr;
                    o_push = 1'b1;
                    if (w_d < EDITION_MIN || w_len_hdr < HEADER_BYTES) begin
                        o_cmd.err = 1'b1;
                        n_phase   = PH_SEARCH;
                        n_window  = '0;
                        n_count   = '0;
                    end else begin
                        o_cmd.lead_word  = 1'b1;
                        o_cmd.body       = {w_d, r_hdr[2], r_hdr[1], r_hdr[0], MARKER_WORD};
                        o_cmd.body_eight = 1'b1;
                        o_cmd.pad        = f_pad(w_len_hdr);
                        o_cmd.total      = f_total(w_len_hdr);
                        if (w_len_hdr == HEADER_BYTES) begin
                            o_cmd.fin = 1'b1;
                            n_phase   = PH_SEARCH;
                            n_window  = '0;
                            n_count   = '0;
                        end else begin
                            n_phase = PH_COPY;
                        end
                    end
                end
            end
            PH_COPY: begin
                o_push         = 1'b1;
                o_cmd.body     = {56'd0, w_d};
                o_cmd.pad      = f_pad(r_len);
                o_cmd.total    = f_total(r_len);
                n_count        = w_count_inc;
                if (w_count_inc >= r_len) begin
                    o_cmd.fin = 1'b1;
                    n_phase   = PH_SEARCH;
                    n_window  = '0;
                    n_count   = '0;
                end
            end
            default: begin
                if (r_window == MARKER_HEAD && w_d == MARKER_TAIL) begin
                    n_phase  = PH_HEADER;
                    n_count  = 24'd4;
                    n_window = '0;
                end else begin
                    n_phase  = PH_SEARCH;
                    n_window = {r_window[15:0], w_d};
                end
            end
        endcase
        if (!w_accept) begin
            n_phase  = r_phase;
            n_window = r_window;
            n_count  = r_count;
            n_len    = r_len;
            o_push   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_window     <= '0;
            r_count      <= '0;
            r_len        <= '0;
            r_word_eight <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_count  <= n_count;
            r_len    <= n_len;
            if (i_cfg_ch.valid) begin
                r_word_eight <= i_cfg_ch.pad_word_eight;
            end
        end
    end

    // Header bytes 4 to 6 hold the big-endian record length.
    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_HEADER) begin
            case (r_count[2:0])
                3'd4:    r_hdr[0] <= w_d;
                3'd5:    r_hdr[1] <= w_d;
                3'd6:    r_hdr[2] <= w_d;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/brb_queue.sv -----
// Short command queue between front and back ends.
`default_nettype none
module brb_queue #(
    parameter int unsigned P_DEPTH = brb_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire brb_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output brb_pkg::t_cmd      o_cmd
);
    import brb_pkg::*;

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);

    t_cmd             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/brb_back.sv -----
// Back end: expands each command into length words, body and pad bytes.
`default_nettype none
module brb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire brb_pkg::t_cmd i_cmd,
    output logic               o_pop,
    brb_out_if.source          o_out_ch
);
    import brb_pkg::*;

    typedef enum logic [1:0] {
        SEG_WORD1 = 2'd0,
        SEG_BODY  = 2'd1,
        SEG_PAD   = 2'd2,
        SEG_WORD2 = 2'd3
    } t_seg;

    t_seg        r_seg, w_seg, w_seg_next;
    logic [2:0]  r_idx, w_idx_max;
    logic        r_out_valid;
    logic [7:0]  r_out_byte, w_byte;
    logic        r_run_last, r_err;
    logic        w_adv, w_seg_end, w_last;
    logic [63:0] w_word;

    assign w_seg  = (r_seg == SEG_WORD1 && !i_cmd.lead_word) ? SEG_BODY : r_seg;
    assign w_word = {39'd0, i_cmd.total};
    assign w_adv  = i_valid && (!r_out_valid || o_out_ch.ready);

    always_comb begin
        unique case (w_seg)
            SEG_WORD1: begin
                w_idx_max  = i_cmd.word_eight ? 3'd7 : 3'd3;
                w_byte     = w_word[{r_idx, 3'b000} +: 8];
                w_seg_next = SEG_BODY;
            end
            SEG_BODY: begin
                w_idx_max  = i_cmd.body_eight ? 3'd7 : 3'd0;
                w_byte     = i_cmd.body[{r_idx, 3'b000} +: 8];
                w_seg_next = SEG_PAD;
            end
            SEG_PAD: begin
                w_idx_max  = 3'(i_cmd.pad - 4'd1);
                w_byte     = 8'd0;
                w_seg_next = SEG_WORD2;
            end
            default: begin
                w_idx_max  = i_cmd.word_eight ? 3'd7 : 3'd3;
                w_byte     = w_word[{r_idx, 3'b000} +: 8];
                w_seg_next = SEG_WORD1;
            end
        endcase
    end

    assign w_seg_end = (r_idx == w_idx_max);
    assign w_last    = w_seg_end &&
                       (w_seg == SEG_WORD2 || (w_seg == SEG_BODY && !i_cmd.fin));
    assign o_pop     = w_adv && w_last;

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.out_byte     = r_out_byte;
    assign o_out_ch.run_last     = r_run_last;
    assign o_out_ch.record_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= SEG_WORD1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
            if (w_last) begin
                r_seg <= SEG_WORD1;
                r_idx <= '0;
            end else if (w_seg_end) begin
                r_seg <= w_seg_next;
                r_idx <= '0;
            end else begin
                r_seg <= w_seg;
                r_idx <= r_idx + 3'd1;
            end
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_run_last <= w_last;
            r_err      <= i_cmd.err;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bufr_record_blocker.sv -----
// Top level of the record blocker: front end, command queue, back end.
//
//  channel    dir  handshake      payload
//  i_in_ch    in   valid/ready    data_byte[7:0]
//  o_out_ch   out  valid/ready    out_byte[7:0], run_last, record_error
//  i_cfg_ch   in   valid/ready    pad_word_eight (ready always high)
//
// One input byte is taken per cycle while the command queue has room.
// The back end sends one output byte per cycle while the sink is ready; a header
// or record end expands to up to 32 bytes, so the input stalls once the queue fills.
// An input transfer reaches its first output byte through the command queue and the output register.
// Synchronous active-low reset clears search state, queue and output valid.
`default_nettype none
module bufr_record_blocker #(
    parameter int unsigned P_QUEUE_DEPTH = brb_pkg::QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    brb_in_if.sink     i_in_ch,
    brb_cfg_if.sink    i_cfg_ch,
    brb_out_if.source  o_out_ch
);
    import brb_pkg::*;

    logic w_push, w_full, w_q_valid, w_pop;
    t_cmd w_push_cmd, w_head_cmd;

    brb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_cfg_ch (i_cfg_ch),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    brb_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    brb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .o_out_ch (o_out_ch)
    );

endmodule
`default_nettype wire

// ----- sim/tb_bufr_record_blocker.sv -----
// Self-checking testbench for the record blocker: byte stimulus, predictor and checker.
`timescale 1ns / 1ps
module tb_bufr_record_blocker;
    import brb_pkg::*;

    typedef enum logic [1:0] {
        ST_SEARCH = 2'd0,
        ST_HEADER = 2'd1,
        ST_COPY   = 2'd2
    } t_rec_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       record_error;
    } t_blocked;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brb_in_if  in_ch ();
    brb_out_if out_ch ();
    brb_cfg_if cfg_ch ();

    bufr_record_blocker u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .i_cfg_ch (cfg_ch),
        .o_out_ch (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    t_rec_state  rec_state      = ST_SEARCH;
    logic [23:0] scan_window    = '0;
    logic [7:0]  hdr_bytes [0:7];
    logic [23:0] taken_count    = '0;
    logic [23:0] rec_len        = '0;
    logic        word_eight_cfg = 1'b0;
    logic [8:0]  burst [0:31];
    int          burst_n;

    t_blocked    blocked_q [$];
    logic [7:0]  raw_q [$];

    int  queued_count   = 0;
    int  accepted_count = 0;
    int  checked_count  = 0;
    int  fail_count     = 0;
    int  good_records   = 0;
    int  bad_headers    = 0;
    int  calm_left [0:1];
    int  in_wait        = 0;
    int  out_wait       = 0;
    bit  in_busy        = 1'b0;
    bit  in_fire        = 1'b0;
    bit  out_fire       = 1'b0;
    bit  squeeze_go     = 1'b0;
    bit  hold_off       = 1'b0;

    function automatic void emit_out(input logic [7:0] b, input logic err);
        burst[burst_n] = {err, b};
        burst_n++;
    endfunction

    function automatic void emit_len_word();
        logic [63:0] total;
        logic [63:0] sh;
        int          i;
        int          n;
        total = {40'd0, rec_len} + 64'd8 - {61'd0, rec_len[2:0]};
        n = word_eight_cfg ? 8 : 4;
        for (i = 0; i < n; i++) begin
            sh = total >> (8 * i);
            emit_out(sh[7:0], 1'b0);
        end
    endfunction

    function automatic void restart_search();
        rec_state   = ST_SEARCH;
        scan_window = '0;
        taken_count = '0;
    endfunction

    // Pad out to the next multiple of eight (a full eight on a multiple), then close.
    function automatic void close_record();
        int i;
        int pad;
        pad = 8 - int'(rec_len[2:0]);
        for (i = 0; i < pad; i++) emit_out(8'h00, 1'b0);
        emit_len_word();
        restart_search();
    endfunction

    function automatic logic [7:0] marker_byte(input int k);
        logic [31:0] sh;
        sh = MARKER_WORD >> (8 * k);
        return sh[7:0];
    endfunction

    // Advance the predictor by one accepted byte and queue the blocked bytes it causes.
    function automatic void block_byte(input logic [7:0] d);
        logic [23:0] len;
        t_blocked    item;
        int          i;
        burst_n = 0;
        case (rec_state)
            ST_HEADER: begin
                hdr_bytes[taken_count[2:0]] = d;
                taken_count = taken_count + 24'd1;
                if (taken_count >= HEADER_BYTES) begin
                    len     = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6]};
                    rec_len = len;
                    if (hdr_bytes[7] < EDITION_MIN || len < HEADER_BYTES) begin
                        emit_out(8'h00, 1'b1);
                        bad_headers++;
                        restart_search();
                    end else begin
                        emit_len_word();
                        for (i = 0; i < 8; i++) emit_out(hdr_bytes[i], 1'b0);
                        good_records++;
                        if (len == HEADER_BYTES) close_record();
                        else rec_state = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                emit_out(d, 1'b0);
                taken_count = taken_count + 24'd1;
                if (taken_count >= rec_len) close_record();
            end
            default: begin
                if (scan_window == MARKER_HEAD && d == MARKER_TAIL) begin
                    for (i = 0; i < 4; i++) hdr_bytes[i] = marker_byte(i);
                    taken_count = 24'd4;
                    rec_state   = ST_HEADER;
                    scan_window = '0;
                end else begin
                    rec_state   = ST_SEARCH;
                    scan_window = {scan_window[15:0], d};
                end
            end
        endcase
        for (i = 0; i < burst_n; i++) begin
            item.out_byte     = burst[i][7:0];
            item.record_error = burst[i][8];
            item.run_last     = (i == burst_n - 1);
            blocked_q.push_back(item);
        end
    endfunction

    // Random idle count, with occasional stretches of no idling at all.
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Input side: record the transfer at the rising edge, drive at the falling edge.
    always @(posedge i_clk) begin : accept
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_fire) begin
            block_byte(in_ch.data_byte);
            accepted_count++;
        end
    end

    always @(negedge i_clk) begin : drive_in
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                in_busy = 1'b0;
                in_wait = draw_gap(0);
            end
            if (!in_busy) begin
                if (in_wait > 0) begin
                    in_wait--;
                    in_ch.valid <= 1'b0;
                end else if (raw_q.size() != 0) begin
                    in_ch.data_byte <= raw_q.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_busy = 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each transfer against the oldest expected byte.
    always @(posedge i_clk) begin : check_out
        t_blocked want;
        out_fire = i_rst_n && out_ch.valid && out_ch.ready;
        if (out_fire) begin
            if (blocked_q.size() == 0) begin
                $display("%0t: unexpected output, nothing expected, got byte %02h last %b err %b",
                         $time, out_ch.out_byte, out_ch.run_last, out_ch.record_error);
                fail_count++;
            end else begin
                want = blocked_q.pop_front();
                checked_count++;
                if (out_ch.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, want.out_byte, out_ch.out_byte);
                    fail_count++;
                end
                if (out_ch.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b got %b",
                             $time, want.run_last, out_ch.run_last);
                    fail_count++;
                end
                if (out_ch.record_error !== want.record_error) begin
                    $display("%0t: record_error expected %b got %b",
                             $time, want.record_error, out_ch.record_error);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_out
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_fire) out_wait = draw_gap(1);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long receiver stall while the sender keeps offering bytes.
    initial begin : squeeze
        wait (squeeze_go);
        repeat ($urandom_range(10, 40)) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic queue_byte(input logic [7:0] b);
        raw_q.push_back(b);
        queued_count++;
    endtask

    task automatic queue_marker(input int n);
        int k;
        for (k = 0; k < n; k++) queue_byte(marker_byte(k));
    endtask

    // Noise never carries the marker tail, so no record starts by accident.
    task automatic queue_noise(input int n);
        logic [7:0] b;
        int         k;
        for (k = 0; k < n; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == MARKER_TAIL) b = ~b;
            queue_byte(b);
        end
    endtask

    // Marker, header and, for a good header, the body; nest places a marker
    // at the body start and a marker head at the body end.
    task automatic add_record(input logic [23:0] len, input logic [7:0] ed, input bit nest);
        int i;
        int n;
        queue_marker(4);
        queue_byte(len[23:16]);
        queue_byte(len[15:8]);
        queue_byte(len[7:0]);
        queue_byte(ed);
        if (ed >= EDITION_MIN && len >= HEADER_BYTES) begin
            n = int'(len);
            for (i = 8; i < n; i++) begin
                if (nest && i < 12) queue_byte(marker_byte(i - 8));
                else if (nest && i >= n - 3) queue_byte(marker_byte(i - (n - 3)));
                else queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic random_traffic(input int target);
        int          start;
        int          r;
        logic [23:0] len;
        start = queued_count;
        while (queued_count - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                r = $urandom_range(0, 99);
                if (r < 85) len = 24'($urandom_range(8, 24));
                else len = 24'($urandom_range(25, 96));
                add_record(len, 8'($urandom_range(2, 255)), $urandom_range(0, 7) == 0);
            end else if (r < 75) begin
                if ($urandom_range(0, 1)) begin
                    add_record(24'($urandom()), 8'($urandom_range(0, 1)), 1'b0);
                end else begin
                    add_record(24'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0);
                end
            end else if (r < 88) begin
                queue_noise($urandom_range(1, 6));
                start = start + 0;
            end else begin
                // broken marker: head of the marker followed by anything but its tail
                queue_marker($urandom_range(2, 3));
                queue_noise(1);
            end
        end
    endtask

    // Hold until every queued byte is taken and every expected byte is out.
    task automatic drain();
        while (accepted_count != queued_count) @(negedge i_clk);
        while (blocked_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_word_size(input logic v);
        @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.pad_word_eight <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        word_eight_cfg = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : scenario
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = 8'h00;
        out_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.pad_word_eight = 1'b0;
        calm_left[0]          = 0;
        calm_left[1]          = 0;
        for (int i = 0; i < 8; i++) hdr_bytes[i] = 8'h00;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise extremes, broken marker, overlapped marker, short record.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_marker(3);
        queue_byte(8'h00);
        queue_byte(marker_byte(0));
        add_record(24'd8, 8'd2, 1'b0);
        // Bad headers: zero length, length seven, low edition at max length.
        add_record(24'd0, 8'd2, 1'b0);
        add_record(24'd7, 8'd255, 1'b0);
        add_record(24'hFFFFFF, 8'd1, 1'b0);
        // Header holding a marker head, then its tail: no rescan after the error.
        add_record(MARKER_HEAD, 8'd0, 1'b0);
        queue_byte(MARKER_TAIL);
        add_record(24'd9, 8'd255, 1'b0);
        // Multiple of eight with a marker inside; the tail after it must be dropped.
        add_record(24'd16, 8'd2, 1'b1);
        queue_byte(MARKER_TAIL);
        drain();

        write_word_size(1'b1);
        squeeze_go = 1'b1;
        add_record(24'd8, 8'd2, 1'b0);
        random_traffic(80);
        drain();

        write_word_size(1'b0);
        random_traffic(80);
        drain();

        $display("Covered %0d input bytes: %0d good records, %0d bad headers,",
                 accepted_count, good_records, bad_headers);
        $display("both length word sizes and a long output stall; %0d output bytes checked.",
                 checked_count);
        if (fail_count == 0 && blocked_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- bufr_record_blocker.f -----
rtl/brb_pkg.sv
rtl/brb_if.sv
rtl/brb_front.sv
rtl/brb_queue.sv
rtl/brb_back.sv
rtl/bufr_record_blocker.sv
sim/tb_bufr_record_blocker.sv
